### hdl/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg
// Shared types and constants for the Euler rotation composer.
// ----------------------------------------------------------------------------
package erc_pkg;

    localparam int ANGLE_W    = 16;
    localparam int KIND_W     = 3;
    localparam int OUT_W      = 16;
    localparam int MAT_DIM    = 3;
    localparam int MAT_DATA_W = MAT_DIM * MAT_DIM * OUT_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_XPOS = 3'd0,
        KIND_YPOS = 3'd1,
        KIND_ZPOS = 3'd2,
        KIND_XROT = 3'd3,
        KIND_YROT = 3'd4,
        KIND_ZROT = 3'd5
    } channel_kind_t;

    // travels alongside each channel through the pipeline
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              last;
    } chan_tag_t;

endpackage

### hdl/erc_phase.sv
// ----------------------------------------------------------------------------
// erc_phase
// Reduces an angle modulo one turn and rounds it to the nearest table phase.
// ----------------------------------------------------------------------------
module erc_phase #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [erc_pkg::ANGLE_W-1:0]  in_angle,
    input  erc_pkg::chan_tag_t                  in_tag,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [$clog2(SINE_TABLE_ENTRIES)-1:0] out_phase,
    output erc_pkg::chan_tag_t                  out_tag
);

    import erc_pkg::*;

    localparam int UNITS_PER_TURN = 23040;
    localparam int HALF_TURN      = UNITS_PER_TURN / 2;
    localparam int TURN_SHIFT     = 9;
    localparam int TURN_ODD       = UNITS_PER_TURN >> TURN_SHIFT;
    localparam int R_W            = 15;
    localparam int PROD_MAX       = (UNITS_PER_TURN - 1) * SINE_TABLE_ENTRIES + HALF_TURN;
    localparam int PROD_W         = $clog2(PROD_MAX + 1);
    localparam int V_W            = PROD_W - TURN_SHIFT;
    localparam int RSH            = V_W + 6;
    localparam longint unsigned RECIP = (64'd1 << RSH) / TURN_ODD;
    localparam int RECIP_W        = RSH - 5;
    localparam int MUL_W          = V_W + RECIP_W;
    localparam int Q_W            = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int K_W            = $clog2(SINE_TABLE_ENTRIES);

    logic                     v1_reg, v2_reg, v3_reg;
    logic                     rdy1, rdy2, rdy3;
    logic signed [ANGLE_W-1:0] ang_reg;
    chan_tag_t                tag1_reg, tag2_reg, tag3_reg;
    logic [V_W-1:0]           vq2_reg, vq3_reg;
    logic [Q_W-1:0]           q3_reg;

    logic signed [17:0]       ang_w;
    logic signed [17:0]       r_w;
    logic [R_W-1:0]           r;
    logic [PROD_W-1:0]        prod;
    logic [V_W-1:0]           v_next;
    logic [MUL_W-1:0]         mul;
    logic [Q_W-1:0]           q_next;
    logic [V_W-1:0]           rem;
    logic [Q_W-1:0]           k_raw;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        ang_w = 18'(ang_reg);
        if (ang_w < -18'sd23040)
            r_w = ang_w + 18'sd46080;
        else if (ang_w < 18'sd0)
            r_w = ang_w + 18'sd23040;
        else if (ang_w >= 18'sd23040)
            r_w = ang_w - 18'sd23040;
        else
            r_w = ang_w;
        r      = r_w[R_W-1:0];
        prod   = PROD_W'(r) * PROD_W'(SINE_TABLE_ENTRIES) + PROD_W'(HALF_TURN);
        v_next = prod[PROD_W-1:TURN_SHIFT];
    end

    always_comb
    begin
        mul    = MUL_W'(vq2_reg) * MUL_W'(RECIP);
        q_next = Q_W'(mul >> RSH);
    end

    // reciprocal estimate is exact or one short
    always_comb
    begin
        rem   = vq3_reg - V_W'(q3_reg) * V_W'(TURN_ODD);
        k_raw = (rem >= V_W'(TURN_ODD)) ? q3_reg + Q_W'(1) : q3_reg;
        if (k_raw == Q_W'(SINE_TABLE_ENTRIES))
            out_phase = '0;
        else
            out_phase = k_raw[K_W-1:0];
    end

    assign out_valid = v3_reg;
    assign out_tag   = tag3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            ang_reg  <= in_angle;
            tag1_reg <= in_tag;
        end
        if (rdy2 && v1_reg)
        begin
            vq2_reg  <= v_next;
            tag2_reg <= tag1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            vq3_reg  <= vq2_reg;
            q3_reg   <= q_next;
            tag3_reg <= tag2_reg;
        end
    end

endmodule

### hdl/erc_trig.sv
// ----------------------------------------------------------------------------
// erc_trig
// Sine and cosine lookup, one registered read per phase.
// ----------------------------------------------------------------------------
module erc_trig #(
    parameter int SINE_TABLE_ENTRIES   = 1024,
    parameter int MATRIX_FRACTION_BITS = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [$clog2(SINE_TABLE_ENTRIES)-1:0] in_phase,
    input  erc_pkg::chan_tag_t                    in_tag,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [MATRIX_FRACTION_BITS+1:0] out_sin,
    output logic signed [MATRIX_FRACTION_BITS+1:0] out_cos,
    output erc_pkg::chan_tag_t                    out_tag
);

    import erc_pkg::*;

    localparam int FW = MATRIX_FRACTION_BITS + 2;
    localparam int SH = 30 - MATRIX_FRACTION_BITS;
    localparam logic [63:0] RND = (SH == 0) ? 64'd0 : (64'd1 << (SH - 1));
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;

    typedef logic [2*FW-1:0] rom_t [SINE_TABLE_ENTRIES];

    // Taylor series to x^13 in Horner form, Q30, folded to the first quadrant
    function automatic logic signed [FW-1:0] trig_frac(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] m;
        logic        neg;
        a   = a_in;
        neg = 1'b0;
        if (a >= Q30_PI)
        begin
            a   = a - Q30_PI;
            neg = 1'b1;
        end
        if (a > Q30_HALF_PI)
            a = Q30_PI - a;
        x2  = (a * a + (64'd1 << 29)) >> 30;
        acc = Q30_ONE;
        acc = Q30_ONE - (((x2 * acc) >> 30) / 64'd156);
        acc = Q30_ONE - (((x2 * acc) >> 30) / 64'd110);
        acc = Q30_ONE - (((x2 * acc) >> 30) / 64'd72);
        acc = Q30_ONE - (((x2 * acc) >> 30) / 64'd42);
        acc = Q30_ONE - (((x2 * acc) >> 30) / 64'd20);
        acc = Q30_ONE - (((x2 * acc) >> 30) / 64'd6);
        s   = (a * acc) >> 30;
        if (s > Q30_ONE)
            s = Q30_ONE;
        m = (s + RND) >> SH;
        return neg ? -FW'(m) : FW'(m);
    endfunction

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] a;
        logic [63:0] ac;
        for (int k = 0; k < SINE_TABLE_ENTRIES; k++)
        begin
            a = (64'(k) * Q30_TWO_PI + 64'(SINE_TABLE_ENTRIES / 2)) / SINE_TABLE_ENTRIES;
            if (a >= Q30_TWO_PI)
                a = a - Q30_TWO_PI;
            ac = a + Q30_HALF_PI;
            if (ac >= Q30_TWO_PI)
                ac = ac - Q30_TWO_PI;
            rom[k] = {trig_frac(a), trig_frac(ac)};
        end
        return rom;
    endfunction

    localparam rom_t TRIG_ROM = build_rom();

    logic            valid_reg;
    logic [2*FW-1:0] trig_reg;
    chan_tag_t       tag_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_sin   = trig_reg[2*FW-1:FW];
    assign out_cos   = trig_reg[FW-1:0];
    assign out_tag   = tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            trig_reg <= TRIG_ROM[in_phase];
            tag_reg  <= in_tag;
        end
    end

endmodule

### hdl/erc_rotator.sv
// ----------------------------------------------------------------------------
// erc_rotator
// Accumulates the joint matrix and holds the finished matrix for output.
// ----------------------------------------------------------------------------
module erc_rotator #(
    parameter int MATRIX_FRACTION_BITS = 14
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [MATRIX_FRACTION_BITS+1:0] in_sin,
    input  logic signed [MATRIX_FRACTION_BITS+1:0] in_cos,
    input  erc_pkg::chan_tag_t                     in_tag,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [erc_pkg::MAT_DATA_W-1:0]         out_data
);

    import erc_pkg::*;

    localparam int FRAC = MATRIX_FRACTION_BITS;
    localparam int EW   = FRAC + 2;
    localparam int SW   = 2 * EW + 1;

    typedef logic signed [EW-1:0] mat_t [MAT_DIM][MAT_DIM];

    mat_t                 acc_reg;
    mat_t                 acc_next;
    mat_t                 out_reg;
    logic                 out_valid_reg;
    logic                 take;
    logic signed [EW-1:0] mp [MAT_DIM];
    logic signed [EW-1:0] mq [MAT_DIM];
    logic signed [EW-1:0] np [MAT_DIM];
    logic signed [EW-1:0] nq [MAT_DIM];

    // round half away from zero, clamp to +-1.0
    function automatic logic signed [EW-1:0] round_sat(input logic signed [SW-1:0] sum);
        logic [SW-1:0] mag;
        logic [SW-1:0] rnd;
        mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
        rnd = (mag + (SW'(1) << (FRAC - 1))) >> FRAC;
        if (rnd > (SW'(1) << FRAC))
            rnd = SW'(1) << FRAC;
        return sum[SW-1] ? -EW'(rnd) : EW'(rnd);
    endfunction

    assign in_ready  = !in_tag.last || !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // columns mixed: X (1,2), Y (2,0), Z (0,1)
    always_comb
    begin
        acc_next = acc_reg;
        for (int i = 0; i < MAT_DIM; i++)
        begin
            case (in_tag.kind)
                KIND_XROT:
                begin
                    mp[i] = acc_reg[i][1];
                    mq[i] = acc_reg[i][2];
                end
                KIND_YROT:
                begin
                    mp[i] = acc_reg[i][2];
                    mq[i] = acc_reg[i][0];
                end
                default:
                begin
                    mp[i] = acc_reg[i][0];
                    mq[i] = acc_reg[i][1];
                end
            endcase
            np[i] = round_sat(SW'(mp[i]) * SW'(in_cos) + SW'(mq[i]) * SW'(in_sin));
            nq[i] = round_sat(SW'(mq[i]) * SW'(in_cos) - SW'(mp[i]) * SW'(in_sin));
            case (in_tag.kind)
                KIND_XROT:
                begin
                    acc_next[i][1] = np[i];
                    acc_next[i][2] = nq[i];
                end
                KIND_YROT:
                begin
                    acc_next[i][2] = np[i];
                    acc_next[i][0] = nq[i];
                end
                KIND_ZROT:
                begin
                    acc_next[i][0] = np[i];
                    acc_next[i][1] = nq[i];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAT_DIM; i++)
                for (int j = 0; j < MAT_DIM; j++)
                    acc_reg[i][j] <= (i == j) ? (EW'(1) << FRAC) : '0;
        end
        else
        begin
            if (take)
            begin
                for (int i = 0; i < MAT_DIM; i++)
                    for (int j = 0; j < MAT_DIM; j++)
                        if (in_tag.last)
                            acc_reg[i][j] <= (i == j) ? (EW'(1) << FRAC) : '0;
                        else
                            acc_reg[i][j] <= acc_next[i][j];
            end
            if (take && in_tag.last)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_tag.last)
            out_reg <= acc_next;
    end

    always_comb
    begin
        for (int i = 0; i < MAT_DIM; i++)
            for (int j = 0; j < MAT_DIM; j++)
                out_data[(i * MAT_DIM + j) * OUT_W +: OUT_W] = OUT_W'(out_reg[i][j]);
    end

endmodule

### hdl/euler_rotation_composer.sv
// ----------------------------------------------------------------------------
// euler_rotation_composer
// Composes a joint's Euler rotation channels into a 3x3 fixed-point matrix.
// ----------------------------------------------------------------------------
// Takes one channel per transfer and sustains one transfer per clock unless a
// last channel waits on an unaccepted matrix. Each channel passes three
// phase-reduction stages, a registered sine/cosine table read and the matrix
// stage, which registers a joint's matrix when its last channel is taken. The
// matrix stage is the only recurrence; its three rows of multiply-adds are
// combinational. Position channels and unused kinds pass through without changing
// the matrix, which returns to identity once a joint's last channel is taken.
module euler_rotation_composer #(
    parameter int SINE_TABLE_ENTRIES   = 1024,
    parameter int MATRIX_FRACTION_BITS = 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [erc_pkg::ANGLE_W-1:0]        s_tdata,   // angle
    input  logic [erc_pkg::KIND_W-1:0]         s_tuser,   // channel_kind
    input  logic                               s_tlast,   // last_channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [erc_pkg::MAT_DATA_W-1:0]     m_tdata    // m00 m01 m02 m10 m11 m12 m20 m21 m22
);

    import erc_pkg::*;

    localparam int K_W = $clog2(SINE_TABLE_ENTRIES);
    localparam int EW  = MATRIX_FRACTION_BITS + 2;

    chan_tag_t            in_tag;
    logic                 ph_valid, ph_ready;
    logic [K_W-1:0]       ph_phase;
    chan_tag_t            ph_tag;
    logic                 tr_valid, tr_ready;
    logic signed [EW-1:0] tr_sin, tr_cos;
    chan_tag_t            tr_tag;

    assign in_tag.kind = s_tuser;
    assign in_tag.last = s_tlast;

    erc_phase #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_angle  (s_tdata),
        .in_tag    (in_tag),
        .out_valid (ph_valid),
        .out_ready (ph_ready),
        .out_phase (ph_phase),
        .out_tag   (ph_tag)
    );

    erc_trig #(
        .SINE_TABLE_ENTRIES   (SINE_TABLE_ENTRIES),
        .MATRIX_FRACTION_BITS (MATRIX_FRACTION_BITS)
    ) u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid),
        .in_ready  (ph_ready),
        .in_phase  (ph_phase),
        .in_tag    (ph_tag),
        .out_valid (tr_valid),
        .out_ready (tr_ready),
        .out_sin   (tr_sin),
        .out_cos   (tr_cos),
        .out_tag   (tr_tag)
    );

    erc_rotator #(
        .MATRIX_FRACTION_BITS (MATRIX_FRACTION_BITS)
    ) u_rotator (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tr_valid),
        .in_ready  (tr_ready),
        .in_sin    (tr_sin),
        .in_cos    (tr_cos),
        .in_tag    (tr_tag),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

### sim/euler_rotation_composer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_rotation_composer_test
// Streams joints of Euler channels into the composer and checks each emitted
// matrix, entry by entry, against a fixed-point rotation predictor kept here.
// A short table of corner channels runs first, then random joints under
// four idling patterns on the input and output streams.
// ----------------------------------------------------------------------------
module euler_rotation_composer_test;

    import erc_pkg::*;

    localparam int TABLE_SIZE    = 1024;
    localparam int FRAC          = 14;
    localparam int TURN          = 23040;
    localparam int N_DIRECTED    = 24;
    localparam int N_PER_PHASE   = 400;
    localparam int DRAIN_CYCLES  = 20;
    localparam int WATCHDOG_MAX  = 4000;

    localparam longint unsigned FRAC_ONE    = 64'd1 << FRAC;
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned Q30_PI      = 64'd3373259426;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
    localparam longint unsigned Q30_TWO_PI  = 64'd6746518852;

    localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

    typedef logic [MAT_DATA_W-1:0] mat_word_t;

    // m22 down to m00
    localparam mat_word_t IDENTITY_WORD = {16'd16384, 16'd0, 16'd0,
                                           16'd0, 16'd16384, 16'd0,
                                           16'd0, 16'd0, 16'd16384};

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ANGLE_W-1:0] angle;
        logic               last;
        logic               ident;
    } chan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [ANGLE_W-1:0]     s_tdata = '0;
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [MAT_DATA_W-1:0]  m_tdata;

    longint    rot_acc [9];
    mat_word_t pending_matrices [$];
    chan_row_t directed_rows [N_DIRECTED];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        errors = 0;
    int        quiet_cycles = 0;

    euler_rotation_composer #(
        .SINE_TABLE_ENTRIES   (TABLE_SIZE),
        .MATRIX_FRACTION_BITS (FRAC)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void load_identity();
        for (int i = 0; i < 9; i++)
            rot_acc[i] = (i % 4 == 0) ? longint'(FRAC_ONE) : 0;
    endfunction

    // signed Q30 sine of a Q30 phase in [0, 2pi)
    function automatic longint sine_q30(input longint unsigned phase);
        longint unsigned x, x2, acc, s;
        bit neg;
        neg = 1'b0;
        x = phase;
        if (x >= Q30_PI)
        begin
            x -= Q30_PI;
            neg = 1'b1;
        end
        if (x > Q30_HALF_PI)
            x = Q30_PI - x;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        acc = Q30_ONE;
        // Horner steps divide by 13*12 down to 3*2
        for (int i = 0; i < 6; i++)
            acc = Q30_ONE - (((x2 * acc) >> 30) / ((12 - 2 * i) * (13 - 2 * i)));
        s = (x * acc) >> 30;
        if (s > Q30_ONE)
            s = Q30_ONE;
        return neg ? -$signed(s) : $signed(s);
    endfunction

    // round half away from zero, saturate to +-1.0
    function automatic longint round_sat(input longint v, input int sh);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        if (m > FRAC_ONE)
            m = FRAC_ONE;
        return (v < 0) ? -$signed(m) : $signed(m);
    endfunction

    function automatic void compose_channel(input logic [KIND_W-1:0] kind,
                                            input logic signed [ANGLE_W-1:0] ang,
                                            input bit last,
                                            output bit emitted,
                                            output mat_word_t word);
        int r, p, q;
        longint unsigned k, a, ac;
        longint c, s, mp, mq;
        emitted = 1'b0;
        word = '0;
        if (kind >= KIND_XROT && kind <= KIND_ZROT)
        begin
            r = int'(ang) % TURN;
            if (r < 0)
                r += TURN;
            k = r;
            k = (k * TABLE_SIZE + TURN / 2) / TURN;
            if (k >= TABLE_SIZE)
                k -= TABLE_SIZE;
            a = (k * Q30_TWO_PI + TABLE_SIZE / 2) / TABLE_SIZE;
            if (a >= Q30_TWO_PI)
                a -= Q30_TWO_PI;
            ac = a + Q30_HALF_PI;
            if (ac >= Q30_TWO_PI)
                ac -= Q30_TWO_PI;
            s = round_sat(sine_q30(a), 30 - FRAC);
            c = round_sat(sine_q30(ac), 30 - FRAC);
            // columns mixed: X (1,2), Y (2,0), Z (0,1)
            p = (kind == KIND_XROT) ? 1 : (kind == KIND_YROT) ? 2 : 0;
            q = (kind == KIND_XROT) ? 2 : (kind == KIND_YROT) ? 0 : 1;
            for (int i = 0; i < 3; i++)
            begin
                mp = rot_acc[i * 3 + p];
                mq = rot_acc[i * 3 + q];
                rot_acc[i * 3 + p] = round_sat(mp * c + mq * s, FRAC);
                rot_acc[i * 3 + q] = round_sat(mq * c - mp * s, FRAC);
            end
        end
        if (last)
        begin
            emitted = 1'b1;
            for (int i = 0; i < 9; i++)
                word[i * OUT_W +: OUT_W] = rot_acc[i][OUT_W-1:0];
            load_identity();
        end
    endfunction

    task automatic send_channel(input logic [KIND_W-1:0] kind,
                                input logic [ANGLE_W-1:0] ang,
                                input bit last,
                                input bit ident);
        bit emitted;
        mat_word_t word;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= ang;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        compose_channel(kind, ang, last, emitted, word);
        if (emitted)
            pending_matrices = {pending_matrices, (ident ? IDENTITY_WORD : word)};
    endtask

    task automatic send_random_joints(input int n_items);
        int sent, n_chan, sel;
        logic [KIND_W-1:0] kind;
        logic [ANGLE_W-1:0] ang;
        sent = 0;
        while (sent < n_items)
        begin
            n_chan = $urandom_range(1, 6);
            for (int j = 0; j < n_chan; j++)
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                    kind = KIND_W'(KIND_XROT + $urandom_range(2));
                else if (sel < 92)
                    kind = KIND_W'(KIND_XPOS + $urandom_range(2));
                else
                    kind = $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
                case ($urandom_range(3))
                    0: ang = ANGLE_W'($urandom);
                    1: ang = ANGLE_W'(int'($urandom_range(400)) - 200);
                    2: ang = ANGLE_W'(1440 * (int'($urandom_range(44)) - 22));
                    default: ang = ANGLE_W'((45 * int'($urandom_range(1023))) / 2
                                   + int'($urandom_range(2)) - 1 - TURN / 2);
                endcase
                send_channel(kind, ang, j == n_chan - 1, 1'b0);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        mat_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_matrices.size() == 0)
                    report_mismatch("matrix transfer with no joint pending");
                else
                begin
                    want = pending_matrices.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (m_tdata[i * OUT_W +: OUT_W] !== want[i * OUT_W +: OUT_W])
                            report_mismatch($sformatf("m%0d%0d got %0d want %0d",
                                i / 3, i % 3,
                                $signed(m_tdata[i * OUT_W +: OUT_W]),
                                $signed(want[i * OUT_W +: OUT_W])));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("euler_rotation_composer_test: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        directed_rows = '{
            '{KIND_XPOS,   16'sd0,      1'b1, 1'b1},
            '{KIND_XROT,   16'sd0,      1'b1, 1'b1},
            '{KIND_YROT,   16'sd23040,  1'b1, 1'b1},
            '{KIND_ZROT,   -16'sd23040, 1'b1, 1'b1},
            '{KIND_SPARE6, 16'sd32767,  1'b0, 1'b0},
            '{KIND_SPARE7, 16'h8000,    1'b0, 1'b0},
            '{KIND_ZPOS,   -16'sd1,     1'b1, 1'b1},
            '{KIND_XROT,   16'sd5760,   1'b1, 1'b0},
            '{KIND_YROT,   -16'sd5760,  1'b1, 1'b0},
            '{KIND_ZROT,   16'sd11520,  1'b1, 1'b0},
            '{KIND_XROT,   16'sd32767,  1'b0, 1'b0},
            '{KIND_YROT,   16'h8000,    1'b0, 1'b0},
            '{KIND_ZROT,   16'sd11,     1'b1, 1'b0},
            '{KIND_ZROT,   16'sd12,     1'b1, 1'b0},
            '{KIND_XROT,   16'sd23039,  1'b1, 1'b0},
            '{KIND_YPOS,   16'sd1234,   1'b0, 1'b0},
            '{KIND_XROT,   16'sd1000,   1'b0, 1'b0},
            '{KIND_ZROT,   16'sd7000,   1'b0, 1'b0},
            '{KIND_XPOS,   16'sd32767,  1'b0, 1'b0},
            '{KIND_YROT,   -16'sd17,    1'b1, 1'b0},
            '{KIND_ZROT,   16'sd2880,   1'b0, 1'b0},
            '{KIND_ZROT,   16'sd2880,   1'b0, 1'b0},
            '{KIND_ZROT,   16'sd2880,   1'b0, 1'b0},
            '{KIND_XROT,   16'sd2880,   1'b1, 1'b0}
        };
        load_identity();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_channel(directed_rows[i].kind, directed_rows[i].angle,
                         directed_rows[i].last, directed_rows[i].ident);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            send_random_joints(N_PER_PHASE);
        end
        s_tvalid <= 1'b0;

        while (pending_matrices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("euler_rotation_composer_test: PASS");
        else
            $display("euler_rotation_composer_test: FAIL");
        $finish;
    end

endmodule

### filelist.f
hdl/erc_pkg.sv
hdl/erc_phase.sv
hdl/erc_trig.sv
hdl/erc_rotator.sv
hdl/euler_rotation_composer.sv
sim/euler_rotation_composer_test.sv
